### hw/rtl/acfd_pkg.sv
// Shared constants, types and codes of the axis command frame deframer.
`default_nettype none

package acfd_pkg;

  localparam int AXES        = 6;
  localparam int FRAME_BYTES = 36;
  localparam int AxisStride  = 6;

  localparam int ByteCntW = 6;
  localparam int FbIdxW   = $clog2(FRAME_BYTES);
  localparam int AxisIdxW = (AXES > 1) ? $clog2(AXES) : 1;

  localparam logic [2:0]          LastAxis    = 3'(AXES - 1);
  localparam logic [ByteCntW-1:0] FrameBytesC = ByteCntW'(FRAME_BYTES);
  localparam logic [ByteCntW-1:0] StrideC     = ByteCntW'(AxisStride);

  localparam logic [15:0] PulseStopped = 16'hffff;
  localparam logic [7:0]  StartCodeRst = 8'hbb;
  localparam logic [7:0]  StopCodeRst  = 8'h1f;
  localparam logic [7:0]  RepeatHit    = 8'd3;

  // configuration register indexes
  localparam logic CfgStartCode = 1'b0;
  localparam logic CfgStopCode  = 1'b1;

  // event kinds
  localparam logic [1:0] EvStart = 2'd0;
  localparam logic [1:0] EvStop  = 2'd1;
  localparam logic [1:0] EvAxis  = 2'd2;

  // timer actions
  localparam logic [1:0] TaNone    = 2'd0;
  localparam logic [1:0] TaEnable  = 2'd1;
  localparam logic [1:0] TaDisable = 2'd2;

  // byte offsets inside one axis record
  localparam logic [1:0] OffLo  = 2'd1;
  localparam logic [1:0] OffHi  = 2'd2;
  localparam logic [1:0] OffDir = 2'd3;

  typedef struct packed {
    logic start;
    logic stop;
    logic frame;
  } job_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [2:0]  axis;
    logic [15:0] pulse_period;
    logic [7:0]  direction;
    logic [1:0]  timer_action;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/acfd_if.sv
// Stream interfaces for received bytes and result beats.
`default_nettype none

interface acfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface acfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [2:0]  axis;
  logic [15:0] pulse_period;
  logic [7:0]  direction;
  logic [1:0]  timer_action;
  logic        last;

  modport source (output valid, output event_kind, output axis, output pulse_period,
                  output direction, output timer_action, output last, input ready);
  modport sink (input valid, input event_kind, input axis, input pulse_period,
                input direction, input timer_action, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/acfd_frame_store.sv
// Frame byte memory: one write port, one registered read port.
`default_nettype none

module acfd_frame_store
  import acfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [FbIdxW-1:0]   waddr_i,
  input  logic [7:0]          wdata_i,
  input  logic [ByteCntW-1:0] raddr_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] mem_q [FRAME_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read past the frame as zero
  always_ff @(posedge clk_i) begin
    if (raddr_i < FrameBytesC) begin
      rdata_q <= mem_q[raddr_i[FbIdxW-1:0]];
    end else begin
      rdata_q <= '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/acfd_rx_track.sv
// Per-byte tracking: byte count, repeat detection, command decode, config registers.
`default_nettype none

module acfd_rx_track
  import acfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  output logic              mem_we_o,
  output logic [FbIdxW-1:0] mem_waddr_o,
  output job_t              job_o
);

  logic [ByteCntW-1:0] bc_q, bc_d, bc_inc;
  logic [7:0]          prev_q, prev_d;
  logic [7:0]          rep_q, rep_d;
  logic [7:0]          cmd_q;
  logic [7:0]          cmd_now;
  logic [7:0]          start_code_q, stop_code_q;
  logic                hit;

  assign bc_inc  = bc_q + ByteCntW'(1);
  assign rep_d   = (rx_byte_i == prev_q) ? rep_q + 8'd1 : 8'd0;
  assign hit     = (rep_d == RepeatHit);
  assign cmd_now = (bc_q == '0) ? rx_byte_i : cmd_q;

  assign mem_we_o    = accept_i && (bc_q < FrameBytesC);
  assign mem_waddr_o = bc_q[FbIdxW-1:0];

  always_comb begin
    job_o.start = hit && (cmd_now == start_code_q);
    job_o.stop  = hit && (cmd_now == stop_code_q);
    job_o.frame = !hit && (bc_inc == FrameBytesC);
    prev_d      = hit ? 8'd0 : rx_byte_i;
    bc_d        = (hit || job_o.frame) ? '0 : bc_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q   <= '0;
      prev_q <= '0;
      rep_q  <= '0;
    end else if (accept_i) begin
      bc_q   <= bc_d;
      prev_q <= prev_d;
      rep_q  <= rep_d;
    end
  end

  // copy of frame byte zero for command decode
  always_ff @(posedge clk_i) begin
    if (accept_i && (bc_q == '0)) begin
      cmd_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= StartCodeRst;
      stop_code_q  <= StopCodeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartCode: start_code_q <= cfg_data_i;
        CfgStopCode:  stop_code_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/acfd_seq.sv
// Result sequencer: walks the frame memory axis by axis and drives the result register.
`default_nettype none

module acfd_seq
  import acfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  job_t                job_i,
  output logic                idle_o,
  output logic [ByteCntW-1:0] mem_raddr_o,
  input  logic [7:0]          mem_rdata_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_STOP  = 7'b0000100,
    S_LO    = 7'b0001000,
    S_HI    = 7'b0010000,
    S_DIR   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic                out_valid_q, out_valid_d;
  res_t                res_q, res_d;
  logic                stop_pend_q, stop_pend_d;
  logic [2:0]          axis_q, axis_d;
  logic [ByteCntW-1:0] base_q, base_d;
  logic [7:0]          lo_q, lo_d, hi_q, hi_d;
  logic [15:0]         prev_pulse_q [AXES];
  logic                pulse_we;
  logic [15:0]         pulse_new, pulse_old;
  logic [1:0]          act;
  logic [1:0]          off;
  logic                out_free;

  assign out_free  = !out_valid_q || res_ready_i;
  assign pulse_new = {hi_q, lo_q};
  assign pulse_old = prev_pulse_q[axis_q[AxisIdxW-1:0]];

  always_comb begin
    if ((pulse_old != PulseStopped) && (pulse_new == PulseStopped)) begin
      act = TaDisable;
    end else if ((pulse_old == PulseStopped) && (pulse_new != PulseStopped)) begin
      act = TaEnable;
    end else begin
      act = TaNone;
    end
  end

  always_comb begin
    case (state_q)
      S_LO:    off = OffLo;
      S_HI:    off = OffHi;
      default: off = OffDir;
    endcase
  end

  assign mem_raddr_o = base_q + {{(ByteCntW-2){1'b0}}, off};

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !res_ready_i;
    res_d       = res_q;
    stop_pend_d = stop_pend_q;
    axis_d      = axis_q;
    base_d      = base_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pulse_we    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          stop_pend_d = job_i.stop;
          axis_d      = '0;
          base_d      = '0;
          if (job_i.start) begin
            state_d = S_START;
          end else if (job_i.stop) begin
            state_d = S_STOP;
          end else if (job_i.frame) begin
            state_d = S_LO;
          end
        end
      end
      S_START: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d       = '{EvStart, 3'd0, 16'd0, 8'd0, TaNone, !stop_pend_q};
          state_d     = stop_pend_q ? S_STOP : S_IDLE;
        end
      end
      S_STOP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d       = '{EvStop, 3'd0, 16'd0, 8'd0, TaNone, 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_LO: begin
        state_d = S_HI;
      end
      S_HI: begin
        lo_d    = mem_rdata_i;
        state_d = S_DIR;
      end
      S_DIR: begin
        hi_d    = mem_rdata_i;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          pulse_we    = 1'b1;
          res_d       = '{EvAxis, axis_q, pulse_new, mem_rdata_i, act, axis_q == LastAxis};
          if (axis_q == LastAxis) begin
            state_d = S_IDLE;
          end else begin
            axis_d  = axis_q + 3'd1;
            base_d  = base_q + StrideC;
            state_d = S_LO;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      stop_pend_q  <= 1'b0;
      axis_q       <= '0;
      base_q       <= '0;
      prev_pulse_q <= '{default: '0};
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      stop_pend_q <= stop_pend_d;
      axis_q      <= axis_d;
      base_q      <= base_d;
      if (pulse_we) begin
        prev_pulse_q[axis_q[AxisIdxW-1:0]] <= pulse_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> state_q == S_IDLE)
    else $error("byte accepted while sequencer busy");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> out_valid_q && res_q.event_kind == EvAxis)
    else $error("axis beat not loaded");

  a_last_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && axis_q == LastAxis) |=>
      state_q == S_IDLE && res_q.last)
    else $error("final axis beat not marked last");

  a_cmd_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STOP && out_free) |=> res_q.last && res_q.event_kind == EvStop)
    else $error("stop beat malformed");

endmodule

`default_nettype wire

### hw/rtl/axis_command_frame_deframer.sv
// Axis command frame deframer top level.
// A byte that yields no result leaves the sequencer idle; the next byte may follow at once.
// A command byte yields its start/stop beats via S_START/S_STOP and the result register.
// A frame's final byte yields six axis beats, each via S_LO, S_HI, S_DIR and S_EMIT (three
// frame memory reads through the single read port, then the result load), ready held low.
// Reset clears the counters, sets start/stop codes to 0xbb/0x1f and previous pulses to zero.
`default_nettype none

module axis_command_frame_deframer
  import acfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  acfd_in_if.sink           rx_i,
  acfd_out_if.source        res_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_data_i
);

  logic                accept;
  logic                seq_idle;
  job_t                job;
  logic                mem_we;
  logic [FbIdxW-1:0]   mem_waddr;
  logic [ByteCntW-1:0] mem_raddr;
  logic [7:0]          mem_rdata;
  res_t                res;

  assign rx_i.ready = seq_idle;
  assign accept     = rx_i.valid && seq_idle;

  acfd_rx_track u_rx_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_i.rx_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .job_o       (job)
  );

  acfd_frame_store u_frame_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (rx_i.rx_byte),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  acfd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .job_i       (job),
    .idle_o      (seq_idle),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.event_kind   = res.event_kind;
  assign res_o.axis         = res.axis;
  assign res_o.pulse_period = res.pulse_period;
  assign res_o.direction    = res.direction;
  assign res_o.timer_action = res.timer_action;
  assign res_o.last         = res.last;

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench: drives received bytes, predicts start/stop and per-axis beats.
`timescale 1ns / 100ps

module tb_top;
  import acfd_pkg::*;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    res_t       beat;
  } dir_row_t;

  localparam res_t NoBeat    = '0;
  localparam res_t StartBeat = '{event_kind: EvStart, axis: 3'd0, pulse_period: 16'd0,
                                 direction: 8'd0, timer_action: TaNone, last: 1'b1};
  localparam res_t StopBeat  = '{event_kind: EvStop, axis: 3'd0, pulse_period: 16'd0,
                                 direction: 8'd0, timer_action: TaNone, last: 1'b1};
  localparam int DirN = 22;
  localparam dir_row_t DirRows [DirN] = '{
    '{8'hbb, 1'b0, NoBeat}, '{8'hbb, 1'b0, NoBeat}, '{8'hbb, 1'b0, NoBeat},
    '{8'hbb, 1'b1, StartBeat},
    '{8'h1f, 1'b0, NoBeat}, '{8'h1f, 1'b0, NoBeat}, '{8'h1f, 1'b0, NoBeat},
    '{8'h1f, 1'b1, StopBeat},
    '{8'h00, 1'b0, NoBeat},
    '{8'hff, 1'b0, NoBeat}, '{8'hff, 1'b0, NoBeat}, '{8'hff, 1'b0, NoBeat},
    '{8'hff, 1'b0, NoBeat},
    '{8'hbb, 1'b0, NoBeat},
    '{8'h55, 1'b0, NoBeat}, '{8'h55, 1'b0, NoBeat}, '{8'h55, 1'b0, NoBeat},
    '{8'h55, 1'b1, StartBeat},
    '{8'h00, 1'b0, NoBeat}, '{8'h00, 1'b0, NoBeat}, '{8'h00, 1'b0, NoBeat},
    '{8'h80, 1'b0, NoBeat}
  };
  localparam int SettleCycles = 40;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_data;

  acfd_in_if  rx_if ();
  acfd_out_if res_if ();

  axis_command_frame_deframer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predictor state
  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [5:0]  byte_cnt;
  logic [7:0]  last_rx;
  logic [7:0]  run_len;
  logic [15:0] prior_pulse [AXES];
  logic [7:0]  start_code;
  logic [7:0]  stop_code;
  res_t        due_beats [$];

  int failures;
  int bytes_sent;
  int beats_from_byte;
  int kind_count [3];
  bit idle_on;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int deframe_byte(input logic [7:0] b);
    int n;
    res_t r;
    logic [15:0] p;
    n = 0;
    if (byte_cnt < FrameBytesC) frame_mem[byte_cnt] = b;
    byte_cnt = byte_cnt + 6'd1;
    run_len = (b == last_rx) ? run_len + 8'd1 : 8'd0;
    last_rx = b;
    if (run_len == RepeatHit) begin
      if (frame_mem[0] == start_code) begin
        r = StartBeat;
        r.last = (frame_mem[0] != stop_code);
        due_beats.push_back(r);
        n++;
      end
      if (frame_mem[0] == stop_code) begin
        due_beats.push_back(StopBeat);
        n++;
      end
      byte_cnt = '0;
      last_rx = '0;
    end
    if (byte_cnt == FrameBytesC) begin
      for (int a = 0; a < AXES; a++) begin
        p = {frame_mem[a * AxisStride + OffHi], frame_mem[a * AxisStride + OffLo]};
        r.event_kind   = EvAxis;
        r.axis         = 3'(a);
        r.pulse_period = p;
        r.direction    = frame_mem[a * AxisStride + OffDir];
        if (prior_pulse[a] != PulseStopped && p == PulseStopped) r.timer_action = TaDisable;
        else if (prior_pulse[a] == PulseStopped && p != PulseStopped) r.timer_action = TaEnable;
        else r.timer_action = TaNone;
        r.last = (a == AXES - 1);
        due_beats.push_back(r);
        prior_pulse[a] = p;
        n++;
      end
      byte_cnt = '0;
    end
    return n;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endfunction

  // hold each byte until accepted; call at a falling edge, returns at one
  task automatic push_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 31) begin
      rx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    beats_from_byte = deframe_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    while (due_beats.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_codes(input logic [7:0] s, input logic [7:0] p);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgStartCode;
    cfg_data <= s;
    @(negedge clk_i);
    cfg_idx  <= CfgStopCode;
    cfg_data <= p;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    start_code = s;
    stop_code  = p;
  endtask

  task automatic send_frame();
    int rem;
    logic [15:0] pulse;
    logic [7:0] b;
    rem = FRAME_BYTES - int'(byte_cnt);
    pulse = '0;
    repeat (rem) begin
      case (int'(byte_cnt) % AxisStride)
        OffLo: begin
          case ($urandom_range(9))
            0, 1, 2, 3: pulse = PulseStopped;
            4: pulse = '0;
            default: pulse = 16'($urandom);
          endcase
          b = pulse[7:0];
        end
        OffHi: b = pulse[15:8];
        default: b = 8'($urandom);
      endcase
      push_byte(b);
    end
  endtask

  task automatic send_command();
    logic [7:0] cmd;
    logic [7:0] x;
    case ($urandom_range(2))
      0: cmd = start_code;
      1: cmd = stop_code;
      default: cmd = 8'($urandom);
    endcase
    x = ($urandom_range(3) == 0) ? cmd : 8'($urandom);
    push_byte(cmd);
    repeat (4) push_byte(x);
  endtask

  task automatic send_noise();
    logic [7:0] x;
    x = 8'($urandom);
    if ($urandom_range(1) == 0) begin
      repeat (3) push_byte(x);
    end else begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
    end
  endtask

  task automatic random_phase(input int count);
    int target;
    int k;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      k = $urandom_range(99);
      if (k < 40) send_frame();
      else if (k < 75) send_command();
      else send_noise();
    end
  endtask

  always @(negedge clk_i) begin
    res_if.ready <= !idle_on || ($urandom_range(99) >= 31);
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{event_kind: res_if.event_kind, axis: res_if.axis,
              pulse_period: res_if.pulse_period, direction: res_if.direction,
              timer_action: res_if.timer_action, last: res_if.last};
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat, actual %p", $time, got);
        failures++;
      end else begin
        want = due_beats.pop_front();
        check_field("event_kind", want.event_kind, got.event_kind);
        check_field("axis", want.axis, got.axis);
        check_field("pulse_period", want.pulse_period, got.pulse_period);
        check_field("direction", want.direction, got.direction);
        check_field("timer_action", want.timer_action, got.timer_action);
        check_field("last", want.last, got.last);
        if (want.event_kind <= EvAxis) kind_count[want.event_kind]++;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgStartCode;
    cfg_data      = '0;
    failures      = 0;
    bytes_sent    = 0;
    idle_on       = 1'b1;
    kind_count    = '{0, 0, 0};
    byte_cnt      = '0;
    last_rx       = '0;
    run_len       = '0;
    start_code    = StartCodeRst;
    stop_code     = StopCodeRst;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    foreach (prior_pulse[i]) prior_pulse[i] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirN; i++) begin
      push_byte(DirRows[i].rx);
      if (DirRows[i].typed) begin
        repeat (beats_from_byte) void'(due_beats.pop_back());
        due_beats.push_back(DirRows[i].beat);
      end
    end

    random_phase(25);
    drain();
    write_codes(8'h00, 8'hff);
    random_phase(25);
    drain();
    write_codes(8'hff, 8'h00);
    random_phase(25);
    drain();
    // back-to-back traffic with equal start and stop codes
    idle_on = 1'b0;
    write_codes(8'ha5, 8'ha5);
    random_phase(25);
    drain();
    idle_on = 1'b1;
    // zero run: repeat count keeps going past a command
    write_codes(8'h00, 8'h00);
    repeat (12) push_byte(8'h00);
    drain();

    $display("Covered %0d bytes over five code settings, ending with a long zero run.",
             bytes_sent);
    $display("Checked %0d start, %0d stop and %0d axis beats (%0d frames).",
             kind_count[EvStart], kind_count[EvStop], kind_count[EvAxis],
             kind_count[EvAxis] / AXES);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d beats still due", due_beats.size());
    $display("FAIL");
    $finish;
  end

endmodule
